// ----- hw/rtl/mvm_pkg.sv -----
// Shared types, widths and helpers for the matrix-vector multiply block.
// No dependencies; used by mvm_seq, mvm_mac and the top level.
package mvm_pkg;

   localparam int MAX_ORDER = 64;
   localparam int ADDR_W    = $clog2(MAX_ORDER);
   localparam int DIM_W     = 7;
   localparam int ORD_W     = ($clog2(MAX_ORDER + 1) > DIM_W) ? $clog2(MAX_ORDER + 1) : DIM_W;
   localparam int VALUE_W   = 32;
   localparam int PROD_W    = 2 * VALUE_W;
   localparam int FRAC_W    = 16;
   localparam int RND_W     = PROD_W - FRAC_W;
   localparam int ACC_W     = 64;
   localparam int ROW_IDX_W = 6;

   localparam logic [DIM_W-1:0]  DIM_RESET = DIM_W'(64);
   localparam logic [PROD_W-1:0] ROUND_BIAS = PROD_W'(1) << (FRAC_W - 1);

   typedef enum logic {
      CMD_LOAD   = 1'b0,
      CMD_MATRIX = 1'b1
   } cmd_type;

   typedef struct packed {
      cmd_type                    cmd;
      logic signed [VALUE_W-1:0]  value;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0]  row_sum;
      logic [ROW_IDX_W-1:0]       row_index;
      logic                       saturated;
      logic                       last;
   } rsp_type;

   // one matrix element headed into the MAC pipeline
   typedef struct packed {
      logic                       valid;
      logic                       row_end;
      logic                       last;
      logic [ADDR_W-1:0]          row;
   } issue_type;

   typedef struct packed {
      logic                       wr_en;
      logic                       rd_en;
      logic [ADDR_W-1:0]          addr;
      logic [VALUE_W-1:0]         wr_data;
   } ram_req_type;

   // dimension zero acts as order 1, anything above the build limit as the limit
   function automatic logic [ORD_W-1:0] order_in_use(input logic [DIM_W-1:0] dim);
      logic [ORD_W-1:0] res;
      if (dim == '0) begin
         res = ORD_W'(1);
      end else if (ORD_W'(dim) > ORD_W'(MAX_ORDER)) begin
         res = ORD_W'(MAX_ORDER);
      end else begin
         res = ORD_W'(dim);
      end
      return res;
   endfunction

endpackage

// ----- hw/rtl/mvm_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module mvm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/mvm_seq.sv -----
// Position sequencer: order register, load/column/row counters, store access.
// Depends on mvm_pkg.
module mvm_seq (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  mvm_pkg::req_type             req_data,
   input  logic                         csr_write,
   input  logic [mvm_pkg::DIM_W-1:0]    csr_data,
   output mvm_pkg::issue_type           issue,
   output mvm_pkg::ram_req_type         ram_req
);

   logic [mvm_pkg::ORD_W-1:0]  order_ff,    order_in;
   logic [mvm_pkg::ADDR_W-1:0] load_pos_ff, load_pos_in;
   logic [mvm_pkg::ADDR_W-1:0] col_pos_ff,  col_pos_in;
   logic [mvm_pkg::ADDR_W-1:0] row_pos_ff,  row_pos_in;

   logic [mvm_pkg::ADDR_W-1:0] lp, cp, rp;
   logic                       load_wrap, row_end, is_last;

   always_comb begin
      // positions left past a lowered order restart at zero
      lp = (mvm_pkg::ORD_W'(load_pos_ff) >= order_ff) ? '0 : load_pos_ff;
      cp = (mvm_pkg::ORD_W'(col_pos_ff)  >= order_ff) ? '0 : col_pos_ff;
      rp = (mvm_pkg::ORD_W'(row_pos_ff)  >= order_ff) ? '0 : row_pos_ff;

      load_wrap = (mvm_pkg::ORD_W'(lp) + mvm_pkg::ORD_W'(1)) >= order_ff;
      row_end   = (mvm_pkg::ORD_W'(cp) + mvm_pkg::ORD_W'(1)) >= order_ff;
      is_last   = (mvm_pkg::ORD_W'(rp) + mvm_pkg::ORD_W'(1)) >= order_ff;

      order_in    = csr_write ? mvm_pkg::order_in_use(csr_data) : order_ff;
      load_pos_in = load_pos_ff;
      col_pos_in  = col_pos_ff;
      row_pos_in  = row_pos_ff;

      issue         = '0;
      ram_req       = '0;
      ram_req.wr_data = req_data.value;

      if (accept) begin
         case (req_data.cmd)
            mvm_pkg::CMD_LOAD: begin
               ram_req.wr_en = 1'b1;
               ram_req.addr  = lp;
               load_pos_in   = load_wrap ? '0 : lp + mvm_pkg::ADDR_W'(1);
            end
            mvm_pkg::CMD_MATRIX: begin
               ram_req.rd_en = 1'b1;
               ram_req.addr  = cp;
               issue.valid   = 1'b1;
               issue.row_end = row_end;
               issue.last    = row_end && is_last;
               issue.row     = rp;
               col_pos_in    = row_end ? '0 : cp + mvm_pkg::ADDR_W'(1);
               if (row_end) begin
                  row_pos_in = is_last ? '0 : rp + mvm_pkg::ADDR_W'(1);
               end else begin
                  row_pos_in = rp;
               end
            end
            default: begin
               load_pos_in = load_pos_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff    <= mvm_pkg::order_in_use(mvm_pkg::DIM_RESET);
         load_pos_ff <= '0;
         col_pos_ff  <= '0;
         row_pos_ff  <= '0;
      end else begin
         order_ff    <= order_in;
         load_pos_ff <= load_pos_in;
         col_pos_ff  <= col_pos_in;
         row_pos_ff  <= row_pos_in;
      end
   end

endmodule

// ----- hw/rtl/mvm_mac.sv -----
// Multiply-accumulate pipeline: multiply, round, accumulate, clamp, result register.
// Depends on mvm_pkg; fed by mvm_seq and the vector store read port.
module mvm_mac (
   input  logic                          clock,
   input  logic                          reset,
   input  mvm_pkg::issue_type            issue,
   input  logic signed [mvm_pkg::VALUE_W-1:0] value,
   input  logic [mvm_pkg::VALUE_W-1:0]   vec_q,
   input  logic                          rsp_stall,
   output logic                          rsp_valid,
   output mvm_pkg::rsp_type              rsp_data,
   output logic                          advance
);

   mvm_pkg::issue_type s1_ff, s1_in, s2_ff, s2_in, s3_ff, s3_in;
   logic signed [mvm_pkg::VALUE_W-1:0] s1_value_ff, s1_value_in;
   logic signed [mvm_pkg::PROD_W-1:0]  prod_ff, prod_in;
   logic signed [mvm_pkg::RND_W-1:0]   rnd_ff, rnd_in;
   logic signed [mvm_pkg::ACC_W-1:0]   acc_ff, acc_in;
   logic signed [mvm_pkg::ACC_W-1:0]   pend_sum_ff, pend_sum_in;
   logic                               pend_valid_ff, pend_valid_in;
   logic [mvm_pkg::ADDR_W-1:0]         pend_row_ff, pend_row_in;
   logic                               pend_last_ff, pend_last_in;
   logic                               out_valid_ff, out_valid_in;
   mvm_pkg::rsp_type                   out_ff, out_in;

   logic signed [mvm_pkg::PROD_W-1:0]  biased;
   logic signed [mvm_pkg::ACC_W-1:0]   sum;
   logic                               load_out, in_range;

   // freeze only when a finished sum is waiting and the result register is blocked
   assign advance  = !(pend_valid_ff && out_valid_ff && rsp_stall);
   assign load_out = pend_valid_ff && advance;

   always_comb begin
      s1_in       = s1_ff;
      s1_value_in = s1_value_ff;
      s2_in       = s2_ff;
      s3_in       = s3_ff;
      prod_in     = prod_ff;
      rnd_in      = rnd_ff;
      acc_in      = acc_ff;

      biased = prod_ff + $signed(mvm_pkg::ROUND_BIAS);
      sum    = acc_ff + mvm_pkg::ACC_W'(rnd_ff);

      pend_valid_in = pend_valid_ff && !advance;
      pend_sum_in   = pend_sum_ff;
      pend_row_in   = pend_row_ff;
      pend_last_in  = pend_last_ff;

      if (advance) begin
         s1_in       = issue;
         s1_value_in = issue.valid ? value : s1_value_ff;
         s2_in       = s1_ff;
         prod_in     = s1_ff.valid ? s1_value_ff * $signed(vec_q) : prod_ff;
         s3_in       = s2_ff;
         rnd_in      = s2_ff.valid ? biased[mvm_pkg::PROD_W-1:mvm_pkg::FRAC_W] : rnd_ff;
         if (s3_ff.valid) begin
            acc_in = s3_ff.row_end ? '0 : sum;
            if (s3_ff.row_end) begin
               pend_valid_in = 1'b1;
               pend_sum_in   = sum;
               pend_row_in   = s3_ff.row;
               pend_last_in  = s3_ff.last;
            end
         end
      end

      // clamp to Q16.16: in range when the top 33 bits agree
      in_range = (pend_sum_ff[mvm_pkg::ACC_W-1:mvm_pkg::VALUE_W-1] == '0) ||
                 (pend_sum_ff[mvm_pkg::ACC_W-1:mvm_pkg::VALUE_W-1] == '1);
      out_in           = out_ff;
      out_valid_in     = out_valid_ff && rsp_stall;
      if (load_out) begin
         out_valid_in        = 1'b1;
         out_in.row_index    = mvm_pkg::ROW_IDX_W'(pend_row_ff);
         out_in.last         = pend_last_ff;
         out_in.saturated    = !in_range;
         if (in_range) begin
            out_in.row_sum = pend_sum_ff[mvm_pkg::VALUE_W-1:0];
         end else if (pend_sum_ff[mvm_pkg::ACC_W-1]) begin
            out_in.row_sum = {1'b1, {(mvm_pkg::VALUE_W-1){1'b0}}};
         end else begin
            out_in.row_sum = {1'b0, {(mvm_pkg::VALUE_W-1){1'b1}}};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff         <= '0;
         s2_ff         <= '0;
         s3_ff         <= '0;
         acc_ff        <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         s1_ff         <= s1_in;
         s2_ff         <= s2_in;
         s3_ff         <= s3_in;
         acc_ff        <= acc_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_value_ff  <= s1_value_in;
      prod_ff      <= prod_in;
      rnd_ff       <= rnd_in;
      pend_sum_ff  <= pend_sum_in;
      pend_row_ff  <= pend_row_in;
      pend_last_ff <= pend_last_in;
      out_ff       <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

// ----- hw/rtl/matrix_vector_multiply.sv -----
// Top level of the dense matrix-vector multiply block, b = A*x in Q16.16.
// Depends on mvm_pkg, mvm_ram, mvm_seq and mvm_mac.
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+-------------------------------------
//  req     | in  | req_valid/req_stall | req_data: cmd, value
//  rsp     | out | rsp_valid/rsp_stall | rsp_data: row_sum, row_index, saturated, last
//  csr     | in  | csr_valid/csr_ready | csr_data: dimension (order n)
//
// One item per clock while req_stall is low, vector loads and matrix
// elements alike; the single store access per item (write for a load,
// read for a matrix element) sets it. Reset is synchronous; it clears
// counters, accumulator and pipeline valids and sets the order to 64.
// The vector store is not cleared. req_stall rises only while a finished
// sum waits behind a stalled result.
module matrix_vector_multiply (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  mvm_pkg::req_type           req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output mvm_pkg::rsp_type           rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [mvm_pkg::DIM_W-1:0]  csr_data
);

   logic                          advance;
   logic                          accept;
   mvm_pkg::issue_type            issue;
   mvm_pkg::ram_req_type          ram_req;
   logic [mvm_pkg::VALUE_W-1:0]   vec_q;

   // config is always taken; only write it while the block is idle (not enforced)
   assign csr_ready = 1'b1;
   assign req_stall = !advance;
   assign accept    = req_valid && advance;

   mvm_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req_data  (req_data),
      .csr_write (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .issue     (issue),
      .ram_req   (ram_req)
   );

   // vector store: written by loads, read one column per matrix element
   mvm_ram #(
      .WIDTH (mvm_pkg::VALUE_W),
      .DEPTH (mvm_pkg::MAX_ORDER)
   ) u_vec_ram (
      .clock   (clock),
      .wr_en   (ram_req.wr_en),
      .wr_addr (ram_req.addr),
      .wr_data (ram_req.wr_data),
      .rd_en   (ram_req.rd_en),
      .rd_addr (ram_req.addr),
      .rd_data (vec_q)
   );

   mvm_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .issue     (issue),
      .value     (req_data.value),
      .vec_q     (vec_q),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .advance   (advance)
   );

   // one shared store address: never a load and a column read together
   a_one_port: assert property (@(posedge clock) disable iff (reset)
      !(ram_req.wr_en && ram_req.rd_en))
      else $error("vector store written and read in the same cycle");

   // input side only backs up behind a blocked result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without a blocked result");

   // a column read only goes out for an accepted matrix element
   a_read_src: assert property (@(posedge clock) disable iff (reset)
      ram_req.rd_en |-> (accept && req_data.cmd == mvm_pkg::CMD_MATRIX && issue.valid))
      else $error("store read without an accepted matrix item");

endmodule

// ----- tb/sv/tb_matrix_vector_multiply.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for matrix_vector_multiply: loads vectors, streams matrix rows and
// checks every row sum field by field against a Q16.16 predictor held in this file.
// Depends on mvm_pkg (payload types, widths) and the matrix_vector_multiply RTL.
module tb_matrix_vector_multiply;
   import mvm_pkg::*;

   localparam int     HALF_PERIOD    = 10;
   localparam int     RESET_CYCLES   = 5;
   localparam int     SETTLE_CYCLES  = 10;
   localparam int     HOLD_CYCLES    = 200;       // long result hold-off
   localparam int     BURST_ITEMS    = 40;        // matrix items offered during the hold
   localparam int     RANDOM_ITEMS   = 730;
   localparam int     DIRECTED_STEPS = 24;
   localparam int     TIMEOUT_NS     = 5_000_000; // far above the slowest legal run
   localparam longint SUM_MAX        = 64'sd2147483647;
   localparam longint SUM_MIN        = -64'sd2147483648;

   // directed table: a register write or an item, with an optional typed-in row sum
   typedef enum logic {
      STEP_CFG  = 1'b0,
      STEP_ITEM = 1'b1
   } step_kind_type;

   typedef struct packed {
      step_kind_type     kind;
      logic [DIM_W-1:0]  dim;
      req_type           item;
      logic              typed;
      rsp_type           want;
   } step_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   req_type           req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   rsp_type           rsp_data;
   logic              csr_valid;
   logic              csr_ready;
   logic [DIM_W-1:0]  csr_data;

   // predictor state: vector copy, 64-bit accumulator, positions and the order register
   logic signed [VALUE_W-1:0] vec_model [MAX_ORDER];
   bit                        vec_written [MAX_ORDER];
   longint                    acc_model = 0;
   int                        load_at = 0;
   int                        col_at = 0;
   int                        row_at = 0;
   logic [DIM_W-1:0]          dim_model = DIM_RESET;

   // row sums still owed by the block, oldest first
   rsp_type pending_sums [$];

   // flow control shared by the sender, the receiver and the sequence
   bit sender_idle   = 1'b1;
   bit receiver_idle = 1'b1;
   bit hold_request  = 1'b0;
   bit req_held      = 1'b0;   // req_valid left high for a back-to-back item
   int pending_gap   = 0;

   int items_sent   = 0;
   int sums_checked = 0;
   int sat_seen     = 0;
   int last_seen    = 0;
   int dims_written = 0;
   int mismatches   = 0;

   // Directed part. Typed row sums are the ones readable at a glance: full-scale
   // products, clipping both ways, wrap of the vector load, rounding ties and a
   // position left beyond a lowered order.
   step_type directed_steps [DIRECTED_STEPS] = '{
      // dimension zero acts as order 1; one element per row
      '{STEP_CFG,  7'd0, '{CMD_LOAD,   32'h0000_0000}, 1'b0, '0},
      '{STEP_ITEM, 7'd0, '{CMD_LOAD,   32'h0001_0000}, 1'b0, '0},
      '{STEP_ITEM, 7'd0, '{CMD_MATRIX, 32'h7FFF_FFFF}, 1'b1,
        '{32'h7FFF_FFFF, 6'd0, 1'b0, 1'b1}},
      '{STEP_ITEM, 7'd0, '{CMD_MATRIX, 32'h8000_0000}, 1'b1,
        '{32'h8000_0000, 6'd0, 1'b0, 1'b1}},
      // order 2, largest magnitudes: clip high on row 0, clip low on the final row
      '{STEP_CFG,  7'd2, '{CMD_LOAD,   32'h0000_0000}, 1'b0, '0},
      '{STEP_ITEM, 7'd0, '{CMD_LOAD,   32'h7FFF_FFFF}, 1'b0, '0},
      '{STEP_ITEM, 7'd0, '{CMD_LOAD,   32'h7FFF_FFFF}, 1'b0, '0},
      '{STEP_ITEM, 7'd0, '{CMD_MATRIX, 32'h7FFF_FFFF}, 1'b0, '0},
      '{STEP_ITEM, 7'd0, '{CMD_MATRIX, 32'h7FFF_FFFF}, 1'b1,
        '{32'h7FFF_FFFF, 6'd0, 1'b1, 1'b0}},
      '{STEP_ITEM, 7'd0, '{CMD_MATRIX, 32'h8000_0000}, 1'b0, '0},
      '{STEP_ITEM, 7'd0, '{CMD_MATRIX, 32'h8000_0000}, 1'b1,
        '{32'h8000_0000, 6'd1, 1'b1, 1'b1}},
      // three loads into two slots: 3.0 overwrites slot 0, vector is {3.0, 2.0}
      '{STEP_ITEM, 7'd0, '{CMD_LOAD,   32'h0001_0000}, 1'b0, '0},
      '{STEP_ITEM, 7'd0, '{CMD_LOAD,   32'h0002_0000}, 1'b0, '0},
      '{STEP_ITEM, 7'd0, '{CMD_LOAD,   32'h0003_0000}, 1'b0, '0},
      '{STEP_ITEM, 7'd0, '{CMD_MATRIX, 32'h0001_0000}, 1'b0, '0},
      '{STEP_ITEM, 7'd0, '{CMD_MATRIX, 32'h0001_0000}, 1'b1,
        '{32'h0005_0000, 6'd0, 1'b0, 1'b0}},
      // slot 1 becomes 0.5; one lsb times 0.5 is a tie, rounds up to one lsb
      '{STEP_ITEM, 7'd0, '{CMD_LOAD,   32'h0000_8000}, 1'b0, '0},
      '{STEP_ITEM, 7'd0, '{CMD_MATRIX, 32'h0000_0000}, 1'b0, '0},
      '{STEP_ITEM, 7'd0, '{CMD_MATRIX, 32'h0000_0001}, 1'b1,
        '{32'h0000_0001, 6'd1, 1'b0, 1'b1}},
      // minus one lsb times 0.5 is a tie, rounds toward plus infinity to zero
      '{STEP_ITEM, 7'd0, '{CMD_MATRIX, 32'h0000_0000}, 1'b0, '0},
      '{STEP_ITEM, 7'd0, '{CMD_MATRIX, 32'hFFFF_FFFF}, 1'b1,
        '{32'h0000_0000, 6'd0, 1'b0, 1'b0}},
      // half a row at order 2, then order 1: positions restart, accumulator kept
      '{STEP_ITEM, 7'd0, '{CMD_MATRIX, 32'h0001_0000}, 1'b0, '0},
      '{STEP_CFG,  7'd1, '{CMD_LOAD,   32'h0000_0000}, 1'b0, '0},
      '{STEP_ITEM, 7'd0, '{CMD_MATRIX, 32'h0001_0000}, 1'b1,
        '{32'h0006_0000, 6'd0, 1'b0, 1'b1}}
   };

   matrix_vector_multiply i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #HALF_PERIOD clock = ~clock;
   end

   // zero reads as order 1, anything above the build limit as the limit
   function automatic int order_of(input logic [DIM_W-1:0] dim);
      if (dim == '0) begin
         return 1;
      end
      if (int'(dim) > MAX_ORDER) begin
         return MAX_ORDER;
      end
      return int'(dim);
   endfunction

   // Advances the predictor by one accepted item; returns 1 with the row sum
   // when the item closes a row.
   function automatic bit predict_row_sum(input req_type item, output rsp_type sum);
      int     n;
      longint prod;
      longint clipped;
      n   = order_of(dim_model);
      sum = '0;
      if (item.cmd == CMD_LOAD) begin
         if (load_at >= n) begin
            load_at = 0;
         end
         vec_model[load_at]   = item.value;
         vec_written[load_at] = 1'b1;
         load_at = (load_at + 1 >= n) ? 0 : load_at + 1;
         return 1'b0;
      end
      if (col_at >= n) begin
         col_at = 0;
      end
      if (row_at >= n) begin
         row_at = 0;
      end
      // exact Q32.32 product, round half up to Q16.16
      prod = longint'($signed(item.value)) * longint'(vec_model[col_at]);
      acc_model += (prod + 64'sd32768) >>> 16;
      if (col_at + 1 < n) begin
         col_at++;
         return 1'b0;
      end
      clipped = acc_model;
      if (acc_model > SUM_MAX) begin
         clipped       = SUM_MAX;
         sum.saturated = 1'b1;
      end else if (acc_model < SUM_MIN) begin
         clipped       = SUM_MIN;
         sum.saturated = 1'b1;
      end
      sum.row_sum   = clipped[VALUE_W-1:0];
      sum.row_index = row_at[ROW_IDX_W-1:0];
      sum.last      = (row_at + 1 >= n);
      acc_model = 0;
      col_at    = 0;
      row_at    = sum.last ? 0 : row_at + 1;
      return 1'b1;
   endfunction

   // random element: mostly within +/-8.0, some full range, some extremes
   function automatic req_type make_item(input cmd_type cmd);
      req_type item;
      item.cmd = cmd;
      case ($urandom_range(0, 7))
         0, 1: begin
            item.value = $urandom;
         end
         2: begin
            case ($urandom_range(0, 4))
               0:       item.value = 32'h7FFF_FFFF;
               1:       item.value = 32'h8000_0000;
               2:       item.value = '0;
               3:       item.value = 32'h0000_0001;
               default: item.value = '1;
            endcase
         end
         default: begin
            item.value = $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
         end
      endcase
      return item;
   endfunction

   // a matrix item may only go out when its column's vector entry was loaded
   function automatic bit column_ready();
      int n;
      n = order_of(dim_model);
      return vec_written[(col_at >= n) ? 0 : col_at];
   endfunction

   // Offers one item, waits for it to be taken and records what it should produce.
   // The gap before the next item is drawn here so that valid stays high when
   // the next item follows back to back.
   task automatic send_item(input req_type item, input logic use_typed = 1'b0,
                            input rsp_type typed = '0);
      rsp_type sum;
      if (!req_held) begin
         repeat (pending_gap) @(posedge clock);
      end
      req_data  <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      items_sent++;
      if (predict_row_sum(item, sum)) begin
         pending_sums.push_back(use_typed ? typed : sum);
      end else if (use_typed) begin
         $error("directed item %0d closes no row", items_sent);
         mismatches++;
      end
      pending_gap = sender_idle ? $urandom_range(0, 4) : 0;
      req_held    = (pending_gap == 0);
      if (!req_held) begin
         req_valid <= 1'b0;
      end
   endtask

   // sender pause: every owed sum back, then the pipeline latency and some margin
   task automatic wait_for_sums();
      if (req_held) begin
         req_valid <= 1'b0;
         req_held = 1'b0;
      end
      while (pending_sums.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_dimension(input logic [DIM_W-1:0] dim);
      csr_data  <= dim;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      dim_model = dim;
      dims_written++;
   endtask

   // Receiver: random stall before each item, or one long hold when asked.
   initial begin
      int stall_cycles;
      rsp_stall <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_request) begin
            stall_cycles = HOLD_CYCLES;
            hold_request = 1'b0;
         end else begin
            stall_cycles = receiver_idle ? $urandom_range(0, 4) : 0;
         end
         if (stall_cycles != 0) begin
            rsp_stall <= 1'b1;
            repeat (stall_cycles) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Result checker: every taken row sum against the oldest owed one.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_sums.size() == 0) begin
            $error("row sum %h for row %0d with none owed", rsp_data.row_sum,
                   rsp_data.row_index);
            mismatches++;
         end else begin
            want = pending_sums.pop_front();
            sums_checked++;
            sat_seen  += want.saturated;
            last_seen += want.last;
            if (rsp_data.row_sum !== want.row_sum) begin
               $error("row_sum: expected %h, got %h", want.row_sum, rsp_data.row_sum);
               mismatches++;
            end
            if (rsp_data.row_index !== want.row_index) begin
               $error("row_index: expected %0d, got %0d", want.row_index,
                      rsp_data.row_index);
               mismatches++;
            end
            if (rsp_data.saturated !== want.saturated) begin
               $error("saturated: expected %b, got %b", want.saturated,
                      rsp_data.saturated);
               mismatches++;
            end
            if (rsp_data.last !== want.last) begin
               $error("last: expected %b, got %b", want.last, rsp_data.last);
               mismatches++;
            end
         end
      end
   end

   // Sequence: reset, directed table, a backpressure burst, then random phases.
   initial begin
      int               n;
      int               count;
      int               phase;
      int               random_start;
      bit               full;
      logic [DIM_W-1:0] dim;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_data  <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_steps[i]) begin
         if (directed_steps[i].kind == STEP_CFG) begin
            wait_for_sums();
            write_dimension(directed_steps[i].dim);
         end else begin
            send_item(directed_steps[i].item, directed_steps[i].typed,
                      directed_steps[i].want);
         end
      end

      // Order 1 gives a sum per matrix item. The receiver holds off for a long
      // stretch while items keep coming back to back, so the block fills and
      // stalls its input; afterwards the sender waits for every sum.
      wait_for_sums();
      write_dimension(7'd1);
      sender_idle = 1'b0;
      send_item(make_item(CMD_LOAD));
      hold_request = 1'b1;
      repeat (BURST_ITEMS) send_item(make_item(CMD_MATRIX));
      wait_for_sums();
      sender_idle = 1'b1;

      // Random phases. The first three force the out-of-range value, the full
      // order and zero. Most phases load a whole vector and stream whole
      // matrices; large orders get a single row. The rest is noise that leaves
      // rows and loads half done across order changes.
      random_start = items_sent;
      phase        = 0;
      while (items_sent - random_start < RANDOM_ITEMS) begin
         wait_for_sums();
         case (phase)
            0:       dim = 7'd127;
            1:       dim = 7'd64;
            2:       dim = 7'd0;
            default: dim = ($urandom_range(0, 19) == 0) ? 7'($urandom_range(65, 127))
                                                        : 7'($urandom_range(0, 8));
         endcase
         if (phase < 3 || $urandom_range(0, 4) != 0) begin
            write_dimension(dim);
         end
         sender_idle   = ($urandom_range(0, 3) != 0);
         receiver_idle = ($urandom_range(0, 3) != 0);
         n = order_of(dim_model);
         if ($urandom_range(0, 9) < 7) begin
            full = 1'b1;
            for (int c = 0; c < n; c++) begin
               full &= vec_written[c];
            end
            if (n <= 8 || !full) begin
               repeat (n) send_item(make_item(CMD_LOAD));
            end
            count = (n <= 8) ? n * n * $urandom_range(1, 3) : n;
            repeat (count) send_item(make_item(CMD_MATRIX));
         end else begin
            repeat ($urandom_range(5, 30)) begin
               if ($urandom_range(0, 9) < 3 || !column_ready()) begin
                  send_item(make_item(CMD_LOAD));
               end else begin
                  send_item(make_item(CMD_MATRIX));
               end
            end
         end
         phase++;
      end
      wait_for_sums();

      $display("Sent %0d items over %0d order settings, one %0d-cycle result hold.",
               items_sent, dims_written, HOLD_CYCLES);
      $display("Checked %0d row sums: %0d clipped, %0d on a final row.",
               sums_checked, sat_seen, last_seen);
      if (mismatches == 0) begin
         $display("tb_matrix_vector_multiply passed");
      end else begin
         $display("tb_matrix_vector_multiply failed");
      end
      $finish;
   end

   // hang guard
   initial begin
      #(TIMEOUT_NS);
      $display("tb_matrix_vector_multiply failed");
      $finish;
   end

endmodule

// ----- files.f -----
hw/rtl/mvm_pkg.sv
hw/rtl/mvm_ram.sv
hw/rtl/mvm_seq.sv
hw/rtl/mvm_mac.sv
hw/rtl/matrix_vector_multiply.sv
tb/sv/tb_matrix_vector_multiply.sv
